[rtl/edist_pkg.sv]
// Shared constants and types of the Euclidean distance engine.
package edist_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned ACC_BITS   = 48;
  localparam int unsigned ROOT_BITS  = (ACC_BITS + 1) / 2;
  localparam int unsigned SQ_BITS    = 2 * COORD_BITS;
  // four lane squares summed need two extra bits
  localparam int unsigned ITEM_BITS  = SQ_BITS + $clog2(LANES);
  localparam int unsigned LCNT_BITS  = 3;

  localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [SQ_BITS-1:0]           sq_t;

  // input word: coordinate pairs for up to four lanes
  typedef struct packed {
    coord_t               a_0;
    coord_t               a_1;
    coord_t               a_2;
    coord_t               a_3;
    coord_t               b_0;
    coord_t               b_1;
    coord_t               b_2;
    coord_t               b_3;
    logic [LCNT_BITS-1:0] lanes_used;
    logic                 last_of_vector;
  } in_word_t;

  // output word: one per vector
  typedef struct packed {
    logic [ACC_BITS-1:0]  squared_distance;
    logic [ROOT_BITS-1:0] distance;
    logic                 saturated;
  } out_word_t;

  // hand-over from the accumulator to the square root unit
  typedef struct packed {
    logic                valid;
    logic [ACC_BITS-1:0] squared;
    logic                sat;
  } sqrt_req_t;

endpackage

[rtl/edist_if.sv]
// Valid/ready channel interfaces for input and output words.
interface edist_in_if
  import edist_pkg::*;
();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface edist_out_if
  import edist_pkg::*;
();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/euclidean_distance_engine_core.sv]
// Euclidean distance engine: lanes, merging accumulator and square root unit.
//
// Input channel in_i carries up to four coordinate pairs per word; lanes_used
// gives how many leading lanes count (values above four count as four, zero
// adds nothing). Words marked last_of_vector close the vector: one output
// word on channel out_o then gives the saturating sum of squared
// differences, its floor square root and a flag if the sum clamped.
// Words that are not last are taken one per cycle: four lanes square their
// pair in the first stage, the merge stage adds the lanes into the 48-bit
// accumulator in the next. A last word is passed to the square root unit,
// which finds one root bit per cycle, then shows the result until it is taken.
// While the root unit is busy or its result waits, a further last word stalls
// in the lane stage and the input stops; words that are not last keep flowing
// until then. The next vector may thus start at once; a vector whose last
// word comes while the root unit still works on the previous one, or while
// that result is stalled, waits.
// Reset clears the accumulator, the saturation flag and all valid flags.
module euclidean_distance_engine_core
  import edist_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  edist_in_if.sink     in_i,
  edist_out_if.source  out_o
);

  coord_t [LANES-1:0] a, b;
  sq_t    [LANES-1:0] sq;
  logic               accept;
  logic               s1_valid_q, s1_last_q;
  logic               s1_go;
  logic               sqrt_free;
  sqrt_req_t          req;

  assign a = {in_i.data.a_3, in_i.data.a_2, in_i.data.a_1, in_i.data.a_0};
  assign b = {in_i.data.b_3, in_i.data.b_2, in_i.data.b_1, in_i.data.b_0};

  // lane stage moves on unless it holds a last word the root unit cannot take
  assign s1_go      = s1_valid_q && (!s1_last_q || sqrt_free);
  assign in_i.ready = !s1_valid_q || s1_go;
  assign accept     = in_i.valid && in_i.ready;

  // lane copies
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    edist_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (accept),
      .lane_on_i (in_i.data.lanes_used > LCNT_BITS'(g)),
      .a_i       (a[g]),
      .b_i       (b[g]),
      .sq_o      (sq[g])
    );
  end

  // lane stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
      s1_last_q  <= in_i.data.last_of_vector;
    end
  end

  edist_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (s1_go),
    .last_i (s1_last_q),
    .sq_i   (sq),
    .req_o  (req)
  );

  edist_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .free_o (sqrt_free),
    .out_o  (out_o)
  );

endmodule

[rtl/edist_lane.sv]
// One lane: squared difference of a coordinate pair, registered.
module edist_lane
  import edist_pkg::*;
(
  input  logic   clk_i,
  input  logic   en_i,
  input  logic   lane_on_i,
  input  coord_t a_i,
  input  coord_t b_i,
  output sq_t    sq_o
);

  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS:0]        neg;
  logic [COORD_BITS-1:0]      mag;
  sq_t                        sq_d, sq_q;

  // |a - b| fits in COORD_BITS unsigned bits
  always_comb begin
    diff = {a_i[COORD_BITS-1], a_i} - {b_i[COORD_BITS-1], b_i};
    neg  = -diff;
    mag  = diff[COORD_BITS] ? neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
    sq_d = lane_on_i ? sq_t'(mag * mag) : '0;
  end

  // payload register, loaded when a word is taken
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

[rtl/edist_merge.sv]
// Merge stage: sums the lane squares into the saturating accumulator.
module edist_merge
  import edist_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic            last_i,
  input  sq_t [LANES-1:0] sq_i,
  output sqrt_req_t       req_o
);

  logic [ACC_BITS-1:0]  acc_d, acc_q;
  logic                 ovf_d, ovf_q;
  logic [ITEM_BITS-1:0] item_sum;
  logic [ACC_BITS:0]    sum;
  logic                 sat;
  logic [ACC_BITS-1:0]  acc_new;

  // adder tree over the lanes, then the saturating add
  always_comb begin
    item_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      item_sum = item_sum + ITEM_BITS'(sq_i[i]);
    end
    sum     = {1'b0, acc_q} + (ACC_BITS + 1)'(item_sum);
    sat     = sum[ACC_BITS];
    acc_new = sat ? ACC_MAX : sum[ACC_BITS-1:0];
  end

  // last word hands the total over and clears the state
  always_comb begin
    acc_d         = acc_q;
    ovf_d         = ovf_q;
    req_o.valid   = go_i && last_i;
    req_o.squared = acc_new;
    req_o.sat     = ovf_q | sat;
    if (go_i) begin
      if (last_i) begin
        acc_d = '0;
        ovf_d = 1'b0;
      end else begin
        acc_d = acc_new;
        ovf_d = ovf_q | sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

[rtl/edist_sqrt.sv]
// Iterative floor square root, one root bit per cycle, with output register.
module edist_sqrt
  import edist_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sqrt_req_t req_i,
  output logic      free_o,
  edist_out_if.source out_o
);

  localparam int unsigned CNT_BITS = $clog2(ROOT_BITS);
  localparam int unsigned REM_BITS = ROOT_BITS + 3;

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DONE
  } state_e;

  state_e               state_q;
  logic [CNT_BITS-1:0]  cnt_q;
  logic [ACC_BITS-1:0]  rad_q;
  logic [REM_BITS-1:0]  rem_q;
  logic [ROOT_BITS-1:0] root_q;
  logic [ACC_BITS-1:0]  sq_q;
  logic                 sat_q;

  logic [REM_BITS-1:0]  rem_t;
  logic [REM_BITS-1:0]  trial;
  logic                 fits;

  // one restoring step: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_t = {rem_q[REM_BITS-3:0], rad_q[ACC_BITS-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
    fits  = rem_t >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      cnt_q   <= '0;
      rad_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
      sq_q    <= '0;
      sat_q   <= 1'b0;
    end else begin
      case (state_q)
        IDLE: begin
          if (req_i.valid) begin
            state_q <= RUN;
            cnt_q   <= '0;
            rad_q   <= req_i.squared;
            rem_q   <= '0;
            root_q  <= '0;
            sq_q    <= req_i.squared;
            sat_q   <= req_i.sat;
          end
        end
        RUN: begin
          rad_q  <= {rad_q[ACC_BITS-3:0], 2'b00};
          rem_q  <= fits ? rem_t - trial : rem_t;
          root_q <= {root_q[ROOT_BITS-2:0], fits};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNT_BITS'(ROOT_BITS - 1)) begin
            state_q <= DONE;
          end
        end
        DONE: begin
          if (out_o.ready) begin
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign free_o                      = (state_q == IDLE);
  assign out_o.valid                 = (state_q == DONE);
  assign out_o.data.squared_distance = sq_q;
  assign out_o.data.distance         = root_q;
  assign out_o.data.saturated        = sat_q;

endmodule

[rtl/edist_checker.sv]
// Port-level checks of the distance engine, bound to the top level.
module edist_checker
  import edist_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_data_i
);

  logic [2*ROOT_BITS+1:0] root_sq;
  logic [2*ROOT_BITS+1:0] root_next_sq;

  assign root_sq      = (2*ROOT_BITS+2)'(out_data_i.distance) *
                        (2*ROOT_BITS+2)'(out_data_i.distance);
  assign root_next_sq = ((2*ROOT_BITS+2)'(out_data_i.distance) + 1'b1) *
                        ((2*ROOT_BITS+2)'(out_data_i.distance) + 1'b1);

  // stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // stalled word keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("output word changed while stalled");

  // distance is the floor root of the squared distance
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> root_sq <= (2*ROOT_BITS+2)'(out_data_i.squared_distance) &&
                    root_next_sq > (2*ROOT_BITS+2)'(out_data_i.squared_distance))
    else $error("distance is not the floor square root");

  // a clamped sum reads as the accumulator maximum
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.saturated |-> out_data_i.squared_distance == ACC_MAX)
    else $error("saturated flag without clamped sum");

endmodule

bind euclidean_distance_engine_core edist_checker u_edist_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
